/* sv/erhp_pkg.sv */
// Package for the receive header parser: item types, parse phases and VLAN TPID constants.
// No dependencies. Imported by every module in this folder.
package erhp_pkg;

    localparam logic [15:0] TPID_CTAG = 16'h8100;
    localparam logic [15:0] TPID_STAG = 16'h88A8;
    localparam logic [15:0] TPID_QINQ = 16'h9100;

    // Offsets of the last byte of each fixed header section, and of the first source byte.
    localparam logic [4:0] LAST_DEST_POS = 5'd5;
    localparam logic [4:0] LAST_SRC_POS  = 5'd11;
    localparam logic [4:0] LAST_STAG_POS = 5'd15;
    localparam logic [4:0] SRC_BASE_POS  = 5'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [2:0]  tag_reason;
        logic [1:0]  tag_vpm;
        logic [4:0]  tag_port;
        logic [15:0] tag_tci;
        logic [1:0]  vlan_count;
        logic [15:0] vlan_tpid;
        logic [15:0] vlan_tci;
        logic [15:0] ether_type;
        logic [4:0]  header_length;
        logic        short_frame;
    } hdr_item_t;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_DEST = 7'b0000010,
        PH_SRC  = 7'b0000100,
        PH_STAG = 7'b0001000,
        PH_CAND = 7'b0010000,
        PH_TCI  = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    function automatic logic is_vlan_tpid(input logic [15:0] tpid);
        return (tpid == TPID_CTAG) || (tpid == TPID_STAG) || (tpid == TPID_QINQ);
    endfunction

endpackage

/* sv/erhp_parser.sv */
// Parse state and per-byte datapath: consumes one request per step and forms the header result.
// Depends on erhp_pkg.
module erhp_parser #(
    parameter int MAX_VLAN_TAGS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  erhp_pkg::rx_item_t item,
    output logic              res_valid,
    output erhp_pkg::hdr_item_t res
);
    import erhp_pkg::*;

    localparam logic [2:0] MaxTags = 3'(MAX_VLAN_TAGS);

    phase_t      phase_reg, phase_next, phase_cur;
    logic [4:0]  pos_reg, pos_next, pos_cur;
    logic [47:0] dest_reg, dest_next;
    logic [47:0] src_reg, src_next;
    logic [31:0] tag_reg, tag_next;
    logic [15:0] cand_reg, cand_next, cand_full;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] tpid_reg, tpid_next;
    logic [15:0] tci_reg, tci_next;
    logic [2:0]  dest_idx, src_idx;
    logic [4:0]  src_off;
    logic        active, hit, short_hit;

    assign phase_cur = item.frame_start ? PH_DEST : phase_reg;
    assign pos_cur   = item.frame_start ? 5'd0 : pos_reg;
    assign dest_idx  = pos_cur[2:0];
    assign src_off   = pos_cur - SRC_BASE_POS;
    assign src_idx   = src_off[2:0];
    assign cand_full = {cand_reg[15:8], item.data_byte};
    assign active    = (phase_cur == PH_DEST) || (phase_cur == PH_SRC) ||
                       (phase_cur == PH_STAG) || (phase_cur == PH_CAND) ||
                       (phase_cur == PH_TCI);

    always_comb
    begin
        phase_next = phase_cur;
        pos_next   = pos_cur;
        dest_next  = item.frame_start ? '0 : dest_reg;
        src_next   = item.frame_start ? '0 : src_reg;
        tag_next   = item.frame_start ? '0 : tag_reg;
        cand_next  = item.frame_start ? '0 : cand_reg;
        cnt_next   = item.frame_start ? '0 : cnt_reg;
        tpid_next  = item.frame_start ? '0 : tpid_reg;
        tci_next   = item.frame_start ? '0 : tci_reg;
        hit        = 1'b0;
        if (active)
        begin
            pos_next = pos_cur + 5'd1;
        end
        case (phase_cur)
            PH_DEST:
            begin
                dest_next[8 * (3'd5 - dest_idx) +: 8] = item.data_byte;
                if (pos_cur == LAST_DEST_POS)
                begin
                    phase_next = PH_SRC;
                end
            end
            PH_SRC:
            begin
                src_next[8 * (3'd5 - src_idx) +: 8] = item.data_byte;
                if (pos_cur == LAST_SRC_POS)
                begin
                    phase_next = PH_STAG;
                end
            end
            PH_STAG:
            begin
                tag_next[8 * (2'd3 - pos_cur[1:0]) +: 8] = item.data_byte;
                if (pos_cur == LAST_STAG_POS)
                begin
                    phase_next = PH_CAND;
                end
            end
            PH_CAND:
            begin
                // Tag fields start on even offsets, so bit 0 picks the byte within a pair.
                if (!pos_cur[0])
                begin
                    cand_next = {item.data_byte, 8'h00};
                end
                else
                begin
                    cand_next = cand_full;
                    if (({1'b0, cnt_next} < MaxTags) && is_vlan_tpid(cand_full))
                    begin
                        if (cnt_next == 2'd0)
                        begin
                            tpid_next = cand_full;
                        end
                        phase_next = PH_TCI;
                    end
                    else
                    begin
                        hit        = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_TCI:
            begin
                if (!pos_cur[0])
                begin
                    if (cnt_next == 2'd0)
                    begin
                        tci_next = {item.data_byte, 8'h00};
                    end
                end
                else
                begin
                    if (cnt_next == 2'd0)
                    begin
                        tci_next = {tci_next[15:8], item.data_byte};
                    end
                    cnt_next   = cnt_next + 2'd1;
                    phase_next = PH_CAND;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase
        short_hit = item.frame_end && active && !hit;
        if (item.frame_end)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        res_valid         = step && (hit || short_hit);
        res.dest_mac      = dest_next;
        res.src_mac       = src_next;
        res.tag_reason    = tag_next[28:26];
        res.tag_vpm       = tag_next[25:24];
        res.tag_port      = tag_next[20:16];
        res.tag_tci       = tag_next[15:0];
        res.vlan_count    = cnt_next;
        res.vlan_tpid     = (cnt_next != 2'd0) ? tpid_next : 16'h0000;
        res.vlan_tci      = (cnt_next != 2'd0) ? tci_next : 16'h0000;
        res.ether_type    = short_hit ? 16'h0000 : cand_next;
        res.header_length = pos_next;
        res.short_frame   = short_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    // Stores are cleared by frame start before any result can read them.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pos_reg  <= pos_next;
            dest_reg <= dest_next;
            src_reg  <= src_next;
            tag_reg  <= tag_next;
            cand_reg <= cand_next;
            cnt_reg  <= cnt_next;
            tpid_reg <= tpid_next;
            tci_reg  <= tci_next;
        end
    end

endmodule

/* sv/ethernet_rx_header_parser_top.sv */
// Top level of the receive header parser: input register, parser and result register.
// Depends on erhp_pkg and erhp_parser.

// The block takes one received frame byte per cycle and returns at most one header request
// per frame, either when the ethertype completes or, with short_frame set, when the frame ends
// first. A byte is held in the input register and is parsed on the way into the result
// register, so hdr_valid rises once the byte that completes the header has moved from the
// input register into the result register. The input side accepts a byte every cycle while
// the result register is empty or is being taken. While a result waits with hdr_ready low,
// the parser holds, and rx_ready drops as soon as the input register is full.
module ethernet_rx_header_parser_top #(
    parameter int MAX_VLAN_TAGS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  erhp_pkg::rx_item_t  rx_item,
    output logic                hdr_valid,
    input  logic                hdr_ready,
    output erhp_pkg::hdr_item_t hdr_item
);
    import erhp_pkg::*;

    logic      in_vld_reg;
    rx_item_t  in_item_reg;
    logic      out_vld_reg;
    hdr_item_t out_item_reg;
    logic      step;
    logic      res_valid;
    hdr_item_t res;

    assign step     = in_vld_reg && (!out_vld_reg || hdr_ready);
    assign rx_ready = !in_vld_reg || step;

    erhp_parser #(
        .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_item_reg),
        .res_valid(res_valid),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_vld_reg <= rx_valid;
            end
            if (step && res_valid)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (hdr_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_item_reg <= rx_item;
        end
        if (step && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign hdr_valid = out_vld_reg;
    assign hdr_item  = out_item_reg;

endmodule

/* sv/erhp_checker.sv */
// Port-level checks for the receive header parser, bound to the top level.
// Depends on erhp_pkg.
module erhp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rx_ready,
    input logic                hdr_valid,
    input logic                hdr_ready,
    input erhp_pkg::hdr_item_t hdr_item
);
    import erhp_pkg::*;

    // A pending header request holds its contents until taken.
    a_hdr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_item))
        else $error("header request changed while stalled");

    // With no header waiting, nothing can hold back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !hdr_valid |-> rx_ready)
        else $error("input stalled with an empty result register");

    a_short_type: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_item.short_frame |-> hdr_item.ether_type == 16'h0000)
        else $error("short frame carries an ethertype");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && !hdr_item.short_frame |->
        hdr_item.header_length == 5'd18 + {1'b0, hdr_item.vlan_count, 2'b00})
        else $error("header length does not match tag count");

    a_no_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_item.vlan_count == 2'd0 |->
        hdr_item.vlan_tpid == 16'h0000 && hdr_item.vlan_tci == 16'h0000)
        else $error("vlan fields set without a counted tag");

endmodule

bind ethernet_rx_header_parser_top erhp_checker u_erhp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_ready (rx_ready),
    .hdr_valid(hdr_valid),
    .hdr_ready(hdr_ready),
    .hdr_item (hdr_item)
);

/* verif/ethernet_rx_header_parser_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for ethernet_rx_header_parser_top: byte stream in, at most one header request per frame out.
// Depends on erhp_pkg and the parser RTL; holds its own header model and a queue of expected headers.
module ethernet_rx_header_parser_top_test;
    import erhp_pkg::*;

    localparam int VLAN_LIMIT   = 3;
    localparam int BYTE_TARGET  = 900;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // Destination all ones, source all zeros, special tag all ones, one 802.1ad tag, ethertype 0.
    localparam logic [175:0] EXTREME_FRAME = {48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF,
                                              TPID_STAG, 16'hFFFF, 16'h0000};

    typedef struct {
        rx_item_t item;
        bit       hold;
    } send_t;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_PATTERN} ready_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_ready;
    rx_item_t  rx_item = '0;
    logic      hdr_valid;
    logic      hdr_ready = 1'b0;
    hdr_item_t hdr_item;

    send_t     pending[$];
    hdr_item_t expected_headers[$];

    // Header model state.
    phase_t      cur_phase = PH_IDLE;
    logic [4:0]  cur_pos = '0;
    logic [47:0] got_dest = '0;
    logic [47:0] got_src = '0;
    logic [31:0] got_tag = '0;
    logic [15:0] got_type = '0;
    logic [1:0]  tag_count = '0;
    logic [15:0] outer_tpid = '0;
    logic [15:0] outer_tci = '0;

    int errors = 0;
    int headers_checked = 0;
    int short_headers = 0;
    int tagged_headers = 0;
    int full_tag_headers = 0;
    int bytes_sent = 0;
    int frames_started = 0;
    int header_bytes = 0;
    int idle_cycles = 0;

    int burst_left = 0;
    int gap_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int mode_left = 0;
    int sparse_period = 2;
    int ready_tick = 0;

    ethernet_rx_header_parser_top #(.MAX_VLAN_TAGS(VLAN_LIMIT)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_item  (rx_item),
        .hdr_valid(hdr_valid),
        .hdr_ready(hdr_ready),
        .hdr_item (hdr_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hdr_item_t header_so_far(input bit cut_short);
        hdr_item_t r;
        r.dest_mac      = got_dest;
        r.src_mac       = got_src;
        r.tag_reason    = got_tag[28:26];
        r.tag_vpm       = got_tag[25:24];
        r.tag_port      = got_tag[20:16];
        r.tag_tci       = got_tag[15:0];
        r.vlan_count    = tag_count;
        r.vlan_tpid     = (tag_count != 0) ? outer_tpid : 16'h0000;
        r.vlan_tci      = (tag_count != 0) ? outer_tci : 16'h0000;
        r.ether_type    = cut_short ? 16'h0000 : got_type;
        r.header_length = cur_pos;
        r.short_frame   = cut_short;
        return r;
    endfunction

    task automatic parse_byte(input rx_item_t it, output bit emitted, output hdr_item_t hdr);
        logic [7:0] b;
        logic [4:0] at;
        b = it.data_byte;
        emitted = 1'b0;
        hdr = '0;
        if (it.frame_start)
        begin
            cur_pos    = '0;
            got_dest   = '0;
            got_src    = '0;
            got_tag    = '0;
            got_type   = '0;
            tag_count  = '0;
            outer_tpid = '0;
            outer_tci  = '0;
            cur_phase  = PH_DEST;
        end
        if (cur_phase == PH_IDLE || cur_phase == PH_DONE)
        begin
            if (it.frame_end)
                cur_phase = PH_IDLE;
        end
        else
        begin
            at = cur_pos;
            cur_pos = cur_pos + 5'd1;
            // Every tag and type section starts at an even offset, so bit 0 picks the byte.
            case (cur_phase)
                PH_DEST:
                begin
                    got_dest[8 * (LAST_DEST_POS - at) +: 8] = b;
                    if (at == LAST_DEST_POS)
                        cur_phase = PH_SRC;
                end
                PH_SRC:
                begin
                    got_src[8 * (LAST_SRC_POS - at) +: 8] = b;
                    if (at == LAST_SRC_POS)
                        cur_phase = PH_STAG;
                end
                PH_STAG:
                begin
                    got_tag[8 * (LAST_STAG_POS - at) +: 8] = b;
                    if (at == LAST_STAG_POS)
                        cur_phase = PH_CAND;
                end
                PH_CAND:
                begin
                    if (!at[0])
                        got_type = {b, 8'h00};
                    else
                    begin
                        got_type[7:0] = b;
                        if (tag_count < VLAN_LIMIT && (got_type == TPID_CTAG ||
                            got_type == TPID_STAG || got_type == TPID_QINQ))
                        begin
                            if (tag_count == 0)
                                outer_tpid = got_type;
                            cur_phase = PH_TCI;
                        end
                        else
                        begin
                            hdr = header_so_far(1'b0);
                            emitted = 1'b1;
                            cur_phase = PH_DONE;
                        end
                    end
                end
                PH_TCI:
                begin
                    // Only the outermost tag keeps its TCI; inner tags are just counted.
                    if (tag_count == 0)
                    begin
                        if (!at[0])
                            outer_tci = {b, 8'h00};
                        else
                            outer_tci[7:0] = b;
                    end
                    if (at[0])
                    begin
                        tag_count = tag_count + 2'd1;
                        cur_phase = PH_CAND;
                    end
                end
                default:
                    ;
            endcase
            if (it.frame_end)
            begin
                if (!emitted)
                begin
                    hdr = header_so_far(1'b1);
                    emitted = 1'b1;
                end
                cur_phase = PH_IDLE;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [47:0] want, input logic [47:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("Header %0d field %s: expected %h, got %h", headers_checked, field,
                         want, got);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last,
                             input bit hold);
        send_t s;
        s.item.data_byte   = b;
        s.item.frame_start = first;
        s.item.frame_end   = last;
        s.hold             = hold;
        pending.push_back(s);
    endtask

    function automatic logic [7:0] rand_byte();
        int w;
        w = $urandom_range(7);
        if (w == 0)
            return 8'h00;
        else if (w == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_tpid();
        case ($urandom_range(2))
            0: return TPID_CTAG;
            1: return TPID_STAG;
            default: return TPID_QINQ;
        endcase
    endfunction

    // keep > 0 and below the frame size cuts the frame to that many bytes; no_end leaves it open for the next start.
    task automatic queue_frame(input int ntags, input logic [15:0] etype, input int keep,
                               input bit no_end, input int tail, input bit hold);
        logic [7:0]  fb[$];
        logic [15:0] tpid;
        int hlen;
        int n;
        for (int i = 0; i < 16; i++)
            fb.push_back(rand_byte());
        for (int t = 0; t < ntags; t++)
        begin
            tpid = pick_tpid();
            fb.push_back(tpid[15:8]);
            fb.push_back(tpid[7:0]);
            fb.push_back(rand_byte());
            fb.push_back(rand_byte());
        end
        fb.push_back(etype[15:8]);
        fb.push_back(etype[7:0]);
        hlen = fb.size();
        for (int p = 0; p < tail; p++)
            fb.push_back(8'($urandom_range(255)));
        n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
        header_bytes += (n < hlen) ? n : hlen;
        for (int i = 0; i < n; i++)
            push_byte(fb[i], i == 0, (i == n - 1) && !no_end, hold && i == 0);
    endtask

    // Sender: bursts of requests with random gaps; a held request waits for all headers to drain.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_item  <= '0;
        end
        else if (!rx_valid || rx_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_valid <= 1'b0;
            end
            else if (pending.size() != 0 &&
                     !(pending[0].hold && (expected_headers.size() != 0 || rx_valid)))
            begin
                rx_item  <= pending[0].item;
                rx_valid <= 1'b1;
                pending.delete(0);
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                rx_valid <= 1'b0;
        end
    end

    // Receiver: ready follows a randomly chosen mode, picked anew whenever its count runs out.
    always @(posedge clk or negedge rst_n)
    begin : recv_pattern
        logic nxt;
        if (!rst_n)
            hdr_ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode    = ready_mode_t'($urandom_range(3));
                mode_left     = $urandom_range(40, 300);
                sparse_period = $urandom_range(2, 8);
            end
            else
                mode_left--;
            ready_tick++;
            case (ready_mode)
                READY_ALWAYS:  nxt = 1'b1;
                READY_RANDOM:  nxt = 1'($urandom_range(1));
                READY_SPARSE:  nxt = (ready_tick % sparse_period) == 0;
                default:       nxt = (ready_tick % 5) != 1 && (ready_tick % 5) != 2;
            endcase
            hdr_ready <= nxt;
        end
    end

    // Checks headers first: a byte taken at this edge cannot produce a header at the same edge.
    always @(posedge clk)
    begin : observe
        hdr_item_t want;
        hdr_item_t made;
        bit        produced;
        if (rst_n)
        begin
            if (hdr_valid && hdr_ready)
            begin
                if (expected_headers.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("Header request with none expected: %h", hdr_item);
                end
                else
                begin
                    want = expected_headers.pop_front();
                    check_field("dest_mac", want.dest_mac, hdr_item.dest_mac);
                    check_field("src_mac", want.src_mac, hdr_item.src_mac);
                    check_field("tag_reason", want.tag_reason, hdr_item.tag_reason);
                    check_field("tag_vpm", want.tag_vpm, hdr_item.tag_vpm);
                    check_field("tag_port", want.tag_port, hdr_item.tag_port);
                    check_field("tag_tci", want.tag_tci, hdr_item.tag_tci);
                    check_field("vlan_count", want.vlan_count, hdr_item.vlan_count);
                    check_field("vlan_tpid", want.vlan_tpid, hdr_item.vlan_tpid);
                    check_field("vlan_tci", want.vlan_tci, hdr_item.vlan_tci);
                    check_field("ether_type", want.ether_type, hdr_item.ether_type);
                    check_field("header_length", want.header_length, hdr_item.header_length);
                    check_field("short_frame", want.short_frame, hdr_item.short_frame);
                    headers_checked++;
                    if (want.short_frame)
                        short_headers++;
                    if (want.vlan_count != 0)
                        tagged_headers++;
                    if (want.vlan_count == VLAN_LIMIT)
                        full_tag_headers++;
                end
            end
            if (rx_valid && rx_ready)
            begin
                parse_byte(rx_item, produced, made);
                if (produced)
                    expected_headers.push_back(made);
                bytes_sent++;
                if (rx_item.frame_start)
                    frames_started++;
            end
            if ((rx_valid && rx_ready) || (hdr_valid && hdr_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int frame_no;
        int sel;
        int w;
        int ntags;
        int tail;
        bit hold;
        logic [15:0] etype;

        // Stray bytes outside any frame, a one-byte frame, and a frame cut off by a new start.
        push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 22; i++)
            push_byte(EXTREME_FRAME[175 - 8 * i -: 8], i == 0, 1'b0, 1'b0);
        // Payload after the ethertype is ignored; the end marker only closes the frame.
        push_byte(8'h5A, 1'b0, 1'b1, 1'b0);

        frame_no = 0;
        while (header_bytes < BYTE_TARGET)
        begin
            w = $urandom_range(99);
            ntags = (w < 35) ? 0 : (w < 65) ? 1 : (w < 85) ? 2 : 3;
            w = $urandom_range(99);
            if (w < 12)
                etype = pick_tpid();
            else if (w < 20)
                etype = pick_tpid() ^ (16'h0001 << $urandom_range(15));
            else
                etype = {rand_byte(), rand_byte()};
            tail = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            hold = (frame_no % 25 == 1) || ($urandom_range(49) == 0);
            sel = $urandom_range(99);
            if (sel < 72)
                queue_frame(ntags, etype, 0, 1'b0, tail, hold);
            else if (sel < 84)
                queue_frame(ntags, etype, $urandom_range(1, 17 + 4 * ntags), 1'b0, 0, hold);
            else if (sel < 90)
                queue_frame(ntags, etype, $urandom_range(1, 18 + 4 * ntags), 1'b1, 0, hold);
            else if (sel < 94)
            begin
                push_byte(8'($urandom_range(255)), 1'b1, 1'b1, hold);
                header_bytes++;
            end
            else
            begin
                w = $urandom_range(1, 3);
                for (int i = 0; i < w; i++)
                    push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
            end
            frame_no++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || rx_valid || expected_headers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes over %0d frame starts; %0d headers checked, %0d short.",
                 bytes_sent, frames_started, headers_checked, short_headers);
        $display("Headers carrying VLAN tags: %0d, with the full tag count: %0d.",
                 tagged_headers, full_tag_headers);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
